@@ rtl/biq_pkg.sv @@
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types, widths and codes for the two-channel TDF-II biquad section.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int CHANNELS    = 2;
  localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int DELAY_BITS  = 48;
  localparam int NUM_COEFS   = 5;
  localparam int COEF_SEL_BITS = $clog2(NUM_COEFS);

  // product of a coefficient and a sample, and its exact difference
  localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS   = PROD_BITS + 1;
  localparam int PROD_SHIFT = SAMPLE_BITS - 9;
  localparam int OUT_SHIFT  = 33 - SAMPLE_BITS;
  localparam int FF_BITS    = PROD_BITS - PROD_SHIFT;
  localparam int TAP_BITS   = ACC_BITS - PROD_SHIFT;
  localparam int SUM_BITS   = DELAY_BITS + 1;
  localparam int OUT_BITS   = SUM_BITS - OUT_SHIFT;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [DELAY_BITS-1:0]  DELAY_MAX  = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [DELAY_BITS-1:0]  DELAY_MIN  = {1'b1, {(DELAY_BITS-1){1'b0}}};

  localparam logic signed [PROD_BITS-1:0] PROD_RND = PROD_BITS'(1) <<< (PROD_SHIFT - 1);
  localparam logic signed [ACC_BITS-1:0]  ACC_RND  = ACC_BITS'(1) <<< (PROD_SHIFT - 1);
  localparam logic signed [SUM_BITS-1:0]  SUM_RND  = SUM_BITS'(1) <<< (OUT_SHIFT - 1);

  // coefficient register indexes
  localparam logic [COEF_SEL_BITS-1:0] COEF_B0 = COEF_SEL_BITS'(0);
  localparam logic [COEF_SEL_BITS-1:0] COEF_B1 = COEF_SEL_BITS'(1);
  localparam logic [COEF_SEL_BITS-1:0] COEF_B2 = COEF_SEL_BITS'(2);
  localparam logic [COEF_SEL_BITS-1:0] COEF_A1 = COEF_SEL_BITS'(3);
  localparam logic [COEF_SEL_BITS-1:0] COEF_A2 = COEF_SEL_BITS'(4);

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(32'd16777216);

  typedef logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_bank_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_ROUND_FF,
    ST_OUT_Y,
    ST_MUL_A1,
    ST_MUL_B2,
    ST_UPD_D1,
    ST_MUL_A2,
    ST_UPD_D2
  } biq_state_e;

  typedef struct packed {
    logic                     load_in;
    logic [COEF_SEL_BITS-1:0] coef_sel;
    logic                     mul_y;
    logic                     ff_en;
    logic                     y_en;
    logic                     acc_load;
    logic                     acc_sub;
    logic                     d1_we;
    logic                     d2_we;
    logic                     out_load;
  } biq_ctrl_t;

endpackage

@@ rtl/biq_ctrl.sv @@
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer that steps the shared multiplier through one biquad update.
// ----------------------------------------------------------------------------
module biq_ctrl
  import biq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  output logic      in_stall_o,
  output biq_ctrl_t ctrl_o
);

  biq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL_B0;
      ST_MUL_B0:   state_d = ST_ROUND_FF;
      ST_ROUND_FF: state_d = ST_OUT_Y;
      ST_OUT_Y:    state_d = ST_MUL_A1;
      ST_MUL_A1:   state_d = ST_MUL_B2;
      ST_MUL_B2:   state_d = ST_UPD_D1;
      ST_UPD_D1:   state_d = ST_MUL_A2;
      ST_MUL_A2:   state_d = ST_UPD_D2;
      ST_UPD_D2:   if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        ctrl_o.load_in = in_valid_i;
      end
      ST_MUL_B0: begin
        ctrl_o.coef_sel = COEF_B0;
      end
      ST_ROUND_FF: begin
        ctrl_o.coef_sel = COEF_B1;
        ctrl_o.ff_en    = 1'b1;
      end
      ST_OUT_Y: begin
        ctrl_o.coef_sel = COEF_B1;
        ctrl_o.y_en     = 1'b1;
        ctrl_o.acc_load = 1'b1;
      end
      ST_MUL_A1: begin
        ctrl_o.coef_sel = COEF_A1;
        ctrl_o.mul_y    = 1'b1;
      end
      ST_MUL_B2: begin
        ctrl_o.coef_sel = COEF_B2;
        ctrl_o.acc_sub  = 1'b1;
      end
      ST_UPD_D1: begin
        ctrl_o.coef_sel = COEF_A2;
        ctrl_o.mul_y    = 1'b1;
        ctrl_o.d1_we    = 1'b1;
        ctrl_o.acc_load = 1'b1;
      end
      ST_MUL_A2: begin
        ctrl_o.coef_sel = COEF_A2;
        ctrl_o.acc_sub  = 1'b1;
      end
      ST_UPD_D2: begin
        ctrl_o.d2_we    = out_free_i;
        ctrl_o.out_load = out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/biq_datapath.sv @@
// ----------------------------------------------------------------------------
// biq_datapath
// Shared multiplier, accumulator and per-channel delay state of the biquad.
// ----------------------------------------------------------------------------
module biq_datapath
  import biq_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  biq_ctrl_t                     ctrl_i,
  input  coef_bank_t                    coef_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          channel_i,
  output logic signed [SAMPLE_BITS-1:0] y_o,
  output logic                          sat_o,
  output logic                          channel_o
);

  logic signed [SAMPLE_BITS-1:0] x_q, y_q, y_d, opnd;
  logic                          ch_q, sat_q, sat_d;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [PROD_BITS-1:0]   prod_d, prod_q, ff_sum;
  logic signed [FF_BITS-1:0]     ff_q;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d;
  logic signed [TAP_BITS-1:0]    tap;
  logic signed [SUM_BITS-1:0]    y_sum, d1_sum;
  logic signed [OUT_BITS-1:0]    y_wide;
  logic signed [DELAY_BITS-1:0]  d1_q [CHANNELS];
  logic signed [DELAY_BITS-1:0]  d2_q [CHANNELS];
  logic signed [DELAY_BITS-1:0]  d1_new;
  logic [CH_BITS-1:0]            slot;
  logic                          y_hi, y_lo;

  assign slot = CH_BITS'(ch_q);

  // shared multiplier
  assign coef   = $signed(coef_i[ctrl_i.coef_sel]);
  assign opnd   = ctrl_i.mul_y ? y_q : x_q;
  assign prod_d = coef * opnd;

  // feedforward term rounded to the delay grid
  assign ff_sum = prod_q + PROD_RND;

  // output: add delay one, round to sample grid, clip
  assign y_sum  = SUM_BITS'(ff_q) + SUM_BITS'(d1_q[slot]) + SUM_RND;
  assign y_wide = y_sum[SUM_BITS-1:OUT_SHIFT];
  assign y_hi   = !y_wide[OUT_BITS-1] && (|y_wide[OUT_BITS-2:SAMPLE_BITS-1]);
  assign y_lo   = y_wide[OUT_BITS-1] && !(&y_wide[OUT_BITS-2:SAMPLE_BITS-1]);

  always_comb begin
    sat_d = y_hi || y_lo;
    priority if (y_hi) begin
      y_d = SAMPLE_MAX;
    end else if (y_lo) begin
      y_d = SAMPLE_MIN;
    end else begin
      y_d = y_wide[SAMPLE_BITS-1:0];
    end
  end

  // accumulator holds the rounding offset plus the exact difference
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_load) begin
      acc_d = ACC_BITS'(prod_q) + ACC_RND;
    end else if (ctrl_i.acc_sub) begin
      acc_d = acc_q - ACC_BITS'(prod_q);
    end
  end

  assign tap    = acc_q[ACC_BITS-1:PROD_SHIFT];
  assign d1_sum = SUM_BITS'(tap) + SUM_BITS'(d2_q[slot]);

  always_comb begin
    if (d1_sum[SUM_BITS-1] != d1_sum[SUM_BITS-2]) begin
      d1_new = d1_sum[SUM_BITS-1] ? DELAY_MIN : DELAY_MAX;
    end else begin
      d1_new = d1_sum[DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctrl_i.load_in) begin
      x_q  <= sample_i;
      ch_q <= channel_i;
    end
    if (ctrl_i.ff_en) begin
      ff_q <= ff_sum[PROD_BITS-1:PROD_SHIFT];
    end
    if (ctrl_i.y_en) begin
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.d1_we) begin
        d1_q[slot] <= d1_new;
      end
      if (ctrl_i.d2_we) begin
        d2_q[slot] <= DELAY_BITS'(tap);
      end
    end
  end

  assign y_o       = y_q;
  assign sat_o     = sat_q;
  assign channel_o = ch_q;

endmodule

@@ rtl/biquad_tdf2_two_channel.sv @@
// ----------------------------------------------------------------------------
// biquad_tdf2_two_channel
// Two-channel second-order IIR section, transposed direct form II, built
// around one shared 32x24 multiplier.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid_i/in_stall_o| sample_in_i[23:0], channel_i
//  output   | out_valid_o/         | sample_out_o[23:0], channel_out_o,
//           |   out_stall_i        |   saturated_o
//  config   | cfg_valid_i/         | cfg_index_i[2:0], cfg_data_i[31:0]
//           |   cfg_ready_o        |
//
//  One transaction is the accept cycle plus eight steps of the
//  sequencer, which pass the five products b0*x, b1*x, a1*y, b2*x and a2*y
//  through the shared multiplier.
//  The result is registered in the last step of the sequencer; if the
//  previous result is still stalled, the last step holds until it drains.
//  Reset clears the delay state of both channels and loads b0 = 1.0, others 0.
//  Coefficient writes are always taken; a write beyond the last index is dropped.
// ----------------------------------------------------------------------------
module biquad_tdf2_two_channel
  import biq_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input samples
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          channel_i,
  // filtered samples
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          channel_out_o,
  output logic                          saturated_o,
  // coefficient writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [COEF_SEL_BITS-1:0]      cfg_index_i,
  input  logic [COEF_BITS-1:0]          cfg_data_i
);

  biq_ctrl_t                     ctrl;
  coef_bank_t                    coef_q;
  logic                          out_free;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, dp_y;
  logic                          out_ch_q, out_sat_q, dp_sat, dp_ch;

  // Coefficient bank: writes land immediately, ignore indexes past the list.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // b0 sits in the lowest slot of the bank
      coef_q <= coef_bank_t'(COEF_ONE);
    end else if (cfg_valid_i && (cfg_index_i < COEF_SEL_BITS'(NUM_COEFS))) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  biq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  biq_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .coef_i    (coef_q),
    .sample_i  (sample_in_i),
    .channel_i (channel_i),
    .y_o       (dp_y),
    .sat_o     (dp_sat),
    .channel_o (dp_ch)
  );

  // Output stage: hold the result while stalled, drop valid once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_sample_q <= dp_y;
      out_ch_q     <= dp_ch;
      out_sat_q    <= dp_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign channel_out_o = out_ch_q;
  assign saturated_o   = out_sat_q;

  // Busy right after a transaction is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  // A stalled result stays on the output unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_out_o) &&
                                      $stable(channel_out_o) && $stable(saturated_o)))
    else $error("stalled result changed or dropped");

  // A clipped result sits at one of the sample rails.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> ((sample_out_o == SAMPLE_MAX) ||
                                      (sample_out_o == SAMPLE_MIN)))
    else $error("saturation flag set on an unclipped sample");

endmodule
